FILE: design/asmr_pkg.sv
// Shared widths, codes, word constants and item/request types for the
// serial multiplexer register block. No dependencies.
`default_nettype none

package asmr_pkg;

   // Geometry
   localparam int CHANNELS = 8;
   localparam int TX_DEPTH = 40;
   localparam int RX_DEPTH = 16;

   // Field widths
   localparam int OP_W   = 3;
   localparam int WORD_W = 16;
   localparam int CH_W   = 3;
   localparam int BYTE_W = 8;
   localparam int CMD_W  = 4;
   localparam int THR_W  = 6;

   // Derived widths
   localparam int TX_PTR_W  = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
   localparam int RX_PTR_W  = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
   localparam int RX_CNT_W  = $clog2(RX_DEPTH + 1);
   localparam int TX_ADDR_W = $clog2(CHANNELS * TX_DEPTH);
   localparam int RX_ADDR_W = (CHANNELS * RX_DEPTH > 1) ? $clog2(CHANNELS * RX_DEPTH) : 1;
   localparam int FILL_CMP_W = (TX_PTR_W > THR_W) ? TX_PTR_W : THR_W;

   // CSR map
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_IDX_BIT  = 2;
   localparam logic REG_OUT_READY_THRESHOLD = 1'b0;
   localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(32);

   // Operations
   localparam logic [OP_W-1:0] OP_CMD_WRITE  = 3'd0;
   localparam logic [OP_W-1:0] OP_HOLD_READ  = 3'd1;
   localparam logic [OP_W-1:0] OP_DATA_WRITE = 3'd2;
   localparam logic [OP_W-1:0] OP_TX_TICK    = 3'd3;
   localparam logic [OP_W-1:0] OP_RX_BYTE    = 3'd4;
   localparam logic [OP_W-1:0] OP_CARRIER    = 3'd5;

   // Commands
   localparam logic [CMD_W-1:0] CMD_POP       = 4'd4;
   localparam logic [CMD_W-1:0] CMD_MODEM     = 4'd5;
   localparam logic [CMD_W-1:0] CMD_IN_STATUS = 4'd6;
   localparam logic [CMD_W-1:0] CMD_TX_STATUS = 4'd7;
   localparam logic [CMD_W-1:0] CMD_TAKE_BACK = 4'd15;

   // Status word bits
   localparam logic [WORD_W-1:0] EMPTY_WORD      = 16'h0080;
   localparam logic [WORD_W-1:0] LOST_BITS       = 16'h3000;
   localparam logic [WORD_W-1:0] NO_CARRIER_WORD = 16'h6000;
   localparam logic [WORD_W-1:0] VALID_BIT       = 16'h8000;
   localparam logic [WORD_W-1:0] IDLE_BIT        = 16'h4000;
   localparam logic [BYTE_W-1:0] CHAR_LF         = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_CR         = 8'h0D;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [WORD_W-1:0] bus_word;
      logic [CH_W-1:0]   event_channel;
      logic [BYTE_W-1:0] event_byte;
      logic              carrier_level;
   } req_item_type;

   // What the result stage must do with one word
   typedef struct packed {
      logic              hold_read;
      logic              tick;
      logic [CH_W-1:0]   tx_channel;
      logic              hold_load;
      logic              hold_pop;
      logic [WORD_W-1:0] hold_value;
   } rsp_info_type;

   typedef struct packed {
      logic                 wr_en;
      logic [TX_ADDR_W-1:0] wr_addr;
      logic [BYTE_W-1:0]    wr_data;
      logic                 rd_en;
      logic [TX_ADDR_W-1:0] rd_addr;
   } tx_mem_req_type;

   typedef struct packed {
      logic                 wr_en;
      logic [RX_ADDR_W-1:0] wr_addr;
      logic [BYTE_W-1:0]    wr_data;
      logic                 rd_en;
      logic [RX_ADDR_W-1:0] rd_addr;
   } rx_mem_req_type;

   function automatic logic [TX_ADDR_W-1:0] tx_addr(input logic [CH_W-1:0] ch,
                                                    input logic [TX_PTR_W-1:0] pos);
      return TX_ADDR_W'(int'(ch) * TX_DEPTH + int'(pos));
   endfunction

   function automatic logic [RX_ADDR_W-1:0] rx_addr(input logic [CH_W-1:0] ch,
                                                    input logic [RX_PTR_W-1:0] pos);
      return RX_ADDR_W'(int'(ch) * RX_DEPTH + int'(pos));
   endfunction

   // Newline is handed to the host as carriage return
   function automatic logic [BYTE_W-1:0] crlf(input logic [BYTE_W-1:0] b);
      return (b == CHAR_LF) ? CHAR_CR : b;
   endfunction

endpackage

`default_nettype wire

FILE: design/async_serial_mux_registers.sv
// Top level of the eight-channel serial multiplexer register block.
// Depends on asmr_pkg, asmr_ram, asmr_csr and asmr_ctrl.
`default_nettype none

// Eight-channel serial multiplexer, register level. Each request word is
// one bus access or line event (command write, holding read, data write,
// transmit tick, receive byte, carrier change) and yields exactly one
// response word. Throughput is one word per clock while the response is
// not stalled. An accepted word first sits in the input register, then
// moves into the response register once that drains. While it sits
// in the input register the per-channel pointers are decoded and the
// transmit ring or receive queue RAM is read or written; the registered
// RAM data is formatted in the response register. A stalled response
// holds the next word in the input register, and with both full req_ready
// drops. The holding word is updated when the response that loads it is
// taken, so a holding read right behind a command sees the new value. The
// 320-byte transmit rings and 128-byte receive queues are plain RAMs with
// no clearing pass; only written entries are ever read.
// out_ready_threshold (byte address 0) resets to 32.

module async_serial_mux_registers
   import asmr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic [OP_W-1:0]       req_operation,
   input  wire logic [WORD_W-1:0]     req_bus_word,
   input  wire logic [CH_W-1:0]       req_event_channel,
   input  wire logic [BYTE_W-1:0]     req_event_byte,
   input  wire logic                  req_carrier_level,

   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic [WORD_W-1:0]     rsp_read_data,
   output      logic                  rsp_tx_valid,
   output      logic [CH_W-1:0]       rsp_tx_channel,
   output      logic [BYTE_W-1:0]     rsp_tx_byte,

   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready
);

   // Input register
   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff, s1_item_in;
   // Response register
   logic         s2_valid_ff, s2_valid_in;
   rsp_info_type s2_info_ff, s2_info_in;
   // Holding word as seen by a holding read
   logic [WORD_W-1:0] holding_ff, holding_in;

   logic              advance;
   logic              req_accept;
   logic              rsp_accept;
   logic [THR_W-1:0]  threshold;
   tx_mem_req_type    tx_req;
   rx_mem_req_type    rx_req;
   rsp_info_type      info;
   logic [BYTE_W-1:0] tx_rd_data;
   logic [BYTE_W-1:0] rx_rd_data;

   // Word moves from input register to response register when the latter
   // is empty or being drained this cycle.
   assign advance    = s1_valid_ff && (!s2_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || advance;
   assign req_accept = req_valid && req_ready;
   assign rsp_accept = s2_valid_ff && rsp_ready;

   asmr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .threshold   (threshold)
   );

   asmr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (s1_item_ff),
      .threshold (threshold),
      .tx_req    (tx_req),
      .rx_req    (rx_req),
      .info      (info)
   );

   // Transmit rings, all channels in one RAM
   asmr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (CHANNELS * TX_DEPTH)
   ) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_req.wr_en),
      .wr_addr (tx_req.wr_addr),
      .wr_data (tx_req.wr_data),
      .rd_en   (tx_req.rd_en),
      .rd_addr (tx_req.rd_addr),
      .rd_data (tx_rd_data)
   );

   // Receive queues
   asmr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (CHANNELS * RX_DEPTH)
   ) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_req.wr_en),
      .wr_addr (rx_req.wr_addr),
      .wr_data (rx_req.wr_data),
      .rd_en   (rx_req.rd_en),
      .rd_addr (rx_req.rd_addr),
      .rd_data (rx_rd_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_item_in  = '{operation:     req_operation,
                         bus_word:      req_bus_word,
                         event_channel: req_event_channel,
                         event_byte:    req_event_byte,
                         carrier_level: req_carrier_level};
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      s2_valid_in = s2_valid_ff;
      s2_info_in  = s2_info_ff;
      if (advance) begin
         s2_valid_in = 1'b1;
         s2_info_in  = info;
      end else if (rsp_accept) begin
         s2_valid_in = 1'b0;
      end

      // Popped byte only exists once the RAM read has landed
      holding_in = holding_ff;
      if (rsp_accept && s2_info_ff.hold_load) begin
         holding_in = s2_info_ff.hold_pop
                      ? (VALID_BIT | WORD_W'(crlf(rx_rd_data)))
                      : s2_info_ff.hold_value;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      s2_info_ff <= s2_info_in;
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         holding_ff  <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         holding_ff  <= holding_in;
      end
   end

   // Response word; both RAM read registers and holding_ff hold still
   // while the response is stalled.
   assign rsp_valid      = s2_valid_ff;
   assign rsp_read_data  = s2_info_ff.hold_read ? holding_ff : '0;
   assign rsp_tx_valid   = s2_info_ff.tick;
   assign rsp_tx_channel = s2_info_ff.tx_channel;
   assign rsp_tx_byte    = s2_info_ff.tick ? tx_rd_data : '0;

   // Holding word changes only when a loading response is taken
   assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && !$stable(holding_ff)
         |-> $past(rsp_valid && rsp_ready && s2_info_ff.hold_load))
      else $error("holding word changed without a loading response");

   // A drained byte and a holding read never share a response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tx_valid |-> rsp_read_data == '0)
      else $error("tick response carries read data");

   // Both stages full and output stalled: no new word may enter
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_valid_ff && !rsp_ready |-> !req_ready)
      else $error("word accepted into a full pipeline");

endmodule

`default_nettype wire

FILE: design/asmr_ram.sv
// Generic single-write, single-read RAM with registered, enabled read.
// No package dependency.
`default_nettype none

module asmr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/asmr_csr.sv
// APB-style configuration port holding the transmit ready threshold.
// Depends on asmr_pkg.
`default_nettype none

module asmr_csr
   import asmr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready,
   output      logic [THR_W-1:0]      threshold
);

   logic [THR_W-1:0] threshold_ff;
   logic [THR_W-1:0] threshold_in;
   logic             hit;

   assign hit        = (csr_paddr[CSR_IDX_BIT] == REG_OUT_READY_THRESHOLD);
   assign csr_pready = 1'b1;

   always_comb begin
      threshold_in = threshold_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         threshold_in = csr_pwdata[THR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   assign csr_prdata = hit ? CSR_DATA_W'(threshold_ff) : '0;
   assign threshold  = threshold_ff;

endmodule

`default_nettype wire

FILE: design/asmr_ctrl.sv
// Per-channel pointer/carrier state and the decode of one word into
// RAM requests and a result-stage action. Depends on asmr_pkg.
`default_nettype none

module asmr_ctrl
   import asmr_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           advance,
   input  wire req_item_type   item,
   input  wire logic [THR_W-1:0] threshold,
   output      tx_mem_req_type tx_req,
   output      rx_mem_req_type rx_req,
   output      rsp_info_type   info
);

   logic [TX_PTR_W-1:0] tx_wr_pos_ff [CHANNELS];
   logic [TX_PTR_W-1:0] tx_wr_pos_in [CHANNELS];
   logic [TX_PTR_W-1:0] tx_rd_pos_ff [CHANNELS];
   logic [TX_PTR_W-1:0] tx_rd_pos_in [CHANNELS];
   logic [RX_CNT_W-1:0] rx_count_ff  [CHANNELS];
   logic [RX_CNT_W-1:0] rx_count_in  [CHANNELS];
   logic [RX_PTR_W-1:0] rx_head_ff   [CHANNELS];
   logic [RX_PTR_W-1:0] rx_head_in   [CHANNELS];
   logic [CHANNELS-1:0] carrier_up_ff, carrier_up_in;
   logic [CHANNELS-1:0] carrier_seen_ff, carrier_seen_in;

   logic [CH_W-1:0]     ch;
   logic                ch_ok;
   logic [CMD_W-1:0]    cmd;
   logic [TX_PTR_W-1:0] wp, rp, wp_next, wp_prev, fill;
   logic [RX_CNT_W-1:0] cnt;
   logic [RX_PTR_W-1:0] head, head_next;
   logic [RX_CNT_W:0]   tail_sum;
   logic [RX_PTR_W-1:0] tail;

   always_comb begin
      cmd   = item.bus_word[CMD_W-1:0];
      ch    = (item.operation == OP_CMD_WRITE || item.operation == OP_DATA_WRITE)
              ? item.bus_word[10:8] : item.event_channel;
      ch_ok = ({1'b0, ch} < (CH_W+1)'(CHANNELS));

      wp   = tx_wr_pos_ff[ch];
      rp   = tx_rd_pos_ff[ch];
      cnt  = rx_count_ff[ch];
      head = rx_head_ff[ch];

      wp_next = (wp == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : wp + 1'b1;
      wp_prev = (wp == '0) ? TX_PTR_W'(TX_DEPTH - 1) : wp - 1'b1;
      fill    = (wp >= rp) ? wp - rp : TX_PTR_W'(TX_DEPTH) + wp - rp;

      head_next = (head == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : head + 1'b1;
      tail_sum  = (RX_CNT_W+1)'(head) + (RX_CNT_W+1)'(cnt);
      tail      = (tail_sum >= (RX_CNT_W+1)'(RX_DEPTH))
                  ? RX_PTR_W'(tail_sum - (RX_CNT_W+1)'(RX_DEPTH))
                  : RX_PTR_W'(tail_sum);
   end

   always_comb begin
      tx_wr_pos_in    = tx_wr_pos_ff;
      tx_rd_pos_in    = tx_rd_pos_ff;
      rx_count_in     = rx_count_ff;
      rx_head_in      = rx_head_ff;
      carrier_up_in   = carrier_up_ff;
      carrier_seen_in = carrier_seen_ff;

      tx_req         = '0;
      tx_req.wr_addr = tx_addr(ch, wp);
      tx_req.wr_data = item.bus_word[BYTE_W-1:0];
      tx_req.rd_addr = tx_addr(ch, rp);
      rx_req         = '0;
      rx_req.wr_addr = rx_addr(ch, tail);
      rx_req.wr_data = item.event_byte;
      rx_req.rd_addr = rx_addr(ch, head);

      info = '0;

      unique case (item.operation)
         OP_CMD_WRITE: begin
            if (ch_ok) begin
               unique case (cmd)
                  CMD_POP: begin
                     info.hold_load = 1'b1;
                     if (cnt == '0) begin
                        info.hold_value = EMPTY_WORD;
                        if (!carrier_up_ff[ch] && carrier_seen_ff[ch]) begin
                           info.hold_value = EMPTY_WORD | LOST_BITS;
                        end
                        carrier_seen_in[ch] = carrier_up_ff[ch];
                     end else begin
                        info.hold_pop   = 1'b1;
                        rx_req.rd_en    = 1'b1;
                        rx_head_in[ch]  = head_next;
                        rx_count_in[ch] = cnt - 1'b1;
                     end
                  end
                  CMD_MODEM: begin
                     info.hold_load  = 1'b1;
                     info.hold_value = carrier_up_ff[ch] ? '0 : NO_CARRIER_WORD;
                  end
                  CMD_IN_STATUS: begin
                     info.hold_load  = 1'b1;
                     info.hold_value = '0;
                  end
                  CMD_TX_STATUS: begin
                     info.hold_load = 1'b1;
                     if (FILL_CMP_W'(fill) < FILL_CMP_W'(threshold)) begin
                        info.hold_value = info.hold_value | VALID_BIT;
                     end
                     if (wp == rp) begin
                        info.hold_value = info.hold_value | IDLE_BIT;
                     end
                  end
                  CMD_TAKE_BACK: begin
                     info.hold_load = 1'b1;
                     if (wp != rp) begin
                        tx_wr_pos_in[ch] = wp_prev;
                        info.hold_value  = (wp_prev == rp) ? '0 : VALID_BIT;
                     end else begin
                        info.hold_value  = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         OP_HOLD_READ: begin
            info.hold_read = 1'b1;
         end
         OP_DATA_WRITE: begin
            if (ch_ok && wp_next != rp) begin
               tx_req.wr_en     = 1'b1;
               tx_wr_pos_in[ch] = wp_next;
            end
         end
         OP_TX_TICK: begin
            if (ch_ok && rp != wp) begin
               tx_req.rd_en     = 1'b1;
               info.tick        = 1'b1;
               info.tx_channel  = ch;
               tx_rd_pos_in[ch] = (rp == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : rp + 1'b1;
            end
         end
         OP_RX_BYTE: begin
            if (ch_ok && cnt < RX_CNT_W'(RX_DEPTH)) begin
               rx_req.wr_en    = 1'b1;
               rx_count_in[ch] = cnt + 1'b1;
            end
         end
         OP_CARRIER: begin
            if (ch_ok) begin
               carrier_up_in[ch] = item.carrier_level;
            end
         end
         default: begin
         end
      endcase

      // Memory strobes only fire when the word actually moves on
      tx_req.wr_en = tx_req.wr_en & advance;
      tx_req.rd_en = tx_req.rd_en & advance;
      rx_req.wr_en = rx_req.wr_en & advance;
      rx_req.rd_en = rx_req.rd_en & advance;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            tx_wr_pos_ff[i] <= '0;
            tx_rd_pos_ff[i] <= '0;
            rx_count_ff[i]  <= '0;
            rx_head_ff[i]   <= '0;
         end
         carrier_up_ff   <= '0;
         carrier_seen_ff <= '0;
      end else if (advance) begin
         tx_wr_pos_ff    <= tx_wr_pos_in;
         tx_rd_pos_ff    <= tx_rd_pos_in;
         rx_count_ff     <= rx_count_in;
         rx_head_ff      <= rx_head_in;
         carrier_up_ff   <= carrier_up_in;
         carrier_seen_ff <= carrier_seen_in;
      end
   end

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking bench for the serial multiplexer register block: it predicts every response
// word from its own copy of rings, queues and carrier state. Needs asmr_pkg and the top level.
`timescale 1ns / 1ps

module testbench;
   import asmr_pkg::*;

   // Operation codes the block must ignore (no package name for them)
   localparam logic [OP_W-1:0]  OP_SPARE_6  = 3'd6;
   localparam logic [OP_W-1:0]  OP_SPARE_7  = 3'd7;
   // A command code with no meaning: holding word must stay as it was
   localparam logic [CMD_W-1:0] CMD_UNUSED  = 4'd0;

   localparam logic [CSR_ADDR_W-1:0] THRESHOLD_ADDR =
      CSR_ADDR_W'(int'(REG_OUT_READY_THRESHOLD) << CSR_IDX_BIT);

   localparam int RESET_CYCLES  = 12;
   localparam int SETTLE_CYCLES = 4;      // lets the input and response registers empty, with margin
   localparam int IDLE_LIMIT    = 2000;   // watchdog bound on the stretch with no word moving
   localparam int PHASE_WORDS   = 155;

   // One response word as the block presents it
   typedef struct packed {
      logic [WORD_W-1:0] read_data;
      logic              tx_valid;
      logic [CH_W-1:0]   tx_channel;
      logic [BYTE_W-1:0] tx_byte;
   } mux_result_type;

   // ---------------------------------------------------------------- DUT ports
   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [OP_W-1:0]       req_operation;
   logic [WORD_W-1:0]     req_bus_word;
   logic [CH_W-1:0]       req_event_channel;
   logic [BYTE_W-1:0]     req_event_byte;
   logic                  req_carrier_level;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [WORD_W-1:0]     rsp_read_data;
   logic                  rsp_tx_valid;
   logic [CH_W-1:0]       rsp_tx_channel;
   logic [BYTE_W-1:0]     rsp_tx_byte;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   async_serial_mux_registers DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_bus_word      (req_bus_word),
      .req_event_channel (req_event_channel),
      .req_event_byte    (req_event_byte),
      .req_carrier_level (req_carrier_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_read_data     (rsp_read_data),
      .rsp_tx_valid      (rsp_tx_valid),
      .rsp_tx_channel    (rsp_tx_channel),
      .rsp_tx_byte       (rsp_tx_byte),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------- shadow copy of the mux
   logic [BYTE_W-1:0]   tx_ring_copy [CHANNELS][TX_DEPTH];
   logic [TX_PTR_W-1:0] tx_wr_at     [CHANNELS];
   logic [TX_PTR_W-1:0] tx_rd_at     [CHANNELS];
   logic [BYTE_W-1:0]   rx_store     [CHANNELS][RX_DEPTH];
   logic [RX_CNT_W-1:0] rx_held      [CHANNELS];
   logic [RX_PTR_W-1:0] rx_first     [CHANNELS];
   logic                carrier_now  [CHANNELS];
   logic                carrier_noted[CHANNELS];   // carrier level at the last empty pop
   logic [WORD_W-1:0]   holding_copy;
   logic [THR_W-1:0]    ready_threshold;

   // Words the block still owes, oldest first
   mux_result_type due_words[$];

   // Bookkeeping
   int  mismatches;
   int  words_checked;
   int  bytes_drained;
   int  bytes_popped;
   int  ring_drops;
   int  queue_drops;
   int  thresholds_used;
   int  idle_cycles;
   int  stall_left;
   bit  sender_steady;     // no gaps between words on the request side
   bit  receiver_steady;   // rsp_ready held high

   task automatic clear_mux_copy();
      for (int c = 0; c < CHANNELS; c++) begin
         for (int i = 0; i < TX_DEPTH; i++) tx_ring_copy[c][i] = '0;
         for (int i = 0; i < RX_DEPTH; i++) rx_store[c][i] = '0;
         tx_wr_at[c]      = '0;
         tx_rd_at[c]      = '0;
         rx_held[c]       = '0;
         rx_first[c]      = '0;
         carrier_now[c]   = 1'b0;
         carrier_noted[c] = 1'b0;
      end
      holding_copy    = '0;
      ready_threshold = THRESHOLD_RESET;
   endtask

   // Advance the shadow state by one accepted word and return the response it owes
   function automatic mux_result_type apply_bus_word(input req_item_type w);
      mux_result_type    r;
      logic [CH_W-1:0]   ch;
      logic [CH_W-1:0]   ech;
      logic [CMD_W-1:0]  cmd;
      logic [BYTE_W-1:0] b;
      int                fill;
      int                nxt;
      r   = '0;
      ch  = w.bus_word[10:8];
      ech = w.event_channel;
      cmd = w.bus_word[CMD_W-1:0];
      case (w.operation)
         OP_CMD_WRITE: begin
            fill = (TX_DEPTH + int'(tx_wr_at[ch]) - int'(tx_rd_at[ch])) % TX_DEPTH;
            case (cmd)
               CMD_POP: begin
                  if (rx_held[ch] == 0) begin
                     // empty queue: report carrier loss once, then remember the level
                     holding_copy = EMPTY_WORD;
                     if (!carrier_now[ch] && carrier_noted[ch]) holding_copy |= LOST_BITS;
                     carrier_noted[ch] = carrier_now[ch];
                  end else begin
                     b = rx_store[ch][rx_first[ch]];
                     rx_first[ch] = RX_PTR_W'((int'(rx_first[ch]) + 1) % RX_DEPTH);
                     rx_held[ch]  = rx_held[ch] - 1'b1;
                     if (b == CHAR_LF) b = CHAR_CR;
                     holding_copy = VALID_BIT | WORD_W'(b);
                     bytes_popped++;
                  end
               end
               CMD_MODEM:     holding_copy = carrier_now[ch] ? '0 : NO_CARRIER_WORD;
               CMD_IN_STATUS: holding_copy = '0;
               CMD_TX_STATUS: begin
                  holding_copy = '0;
                  if (fill < int'(ready_threshold)) holding_copy |= VALID_BIT;
                  if (fill == 0) holding_copy |= IDLE_BIT;
               end
               CMD_TAKE_BACK: begin
                  if (fill != 0)
                     tx_wr_at[ch] = TX_PTR_W'((int'(tx_wr_at[ch]) + TX_DEPTH - 1) % TX_DEPTH);
                  holding_copy = (tx_wr_at[ch] == tx_rd_at[ch]) ? '0 : VALID_BIT;
               end
               default: ;
            endcase
         end
         OP_HOLD_READ: r.read_data = holding_copy;
         OP_DATA_WRITE: begin
            // ring keeps one slot free; a write into a full ring is lost
            nxt = (int'(tx_wr_at[ch]) + 1) % TX_DEPTH;
            if (nxt != int'(tx_rd_at[ch])) begin
               tx_ring_copy[ch][tx_wr_at[ch]] = w.bus_word[BYTE_W-1:0];
               tx_wr_at[ch] = TX_PTR_W'(nxt);
            end else begin
               ring_drops++;
            end
         end
         OP_TX_TICK: begin
            if (tx_rd_at[ech] != tx_wr_at[ech]) begin
               r.tx_valid   = 1'b1;
               r.tx_channel = ech;
               r.tx_byte    = tx_ring_copy[ech][tx_rd_at[ech]];
               tx_rd_at[ech] = TX_PTR_W'((int'(tx_rd_at[ech]) + 1) % TX_DEPTH);
               bytes_drained++;
            end
         end
         OP_RX_BYTE: begin
            if (rx_held[ech] < RX_DEPTH) begin
               rx_store[ech][(int'(rx_first[ech]) + int'(rx_held[ech])) % RX_DEPTH] =
                  w.event_byte;
               rx_held[ech] = rx_held[ech] + 1'b1;
            end else begin
               queue_drops++;
            end
         end
         OP_CARRIER: carrier_now[ech] = w.carrier_level;
         default: ;
      endcase
      return r;
   endfunction

   // ----------------------------------------------------------- word builders
   function automatic logic [WORD_W-1:0] cmd_word(input logic [CH_W-1:0] ch,
                                                  input logic [CMD_W-1:0] cmd);
      return {5'($urandom), ch, 4'($urandom), cmd};
   endfunction

   function automatic logic [WORD_W-1:0] data_word(input logic [CH_W-1:0] ch,
                                                   input logic [BYTE_W-1:0] b);
      return {5'($urandom), ch, b};
   endfunction

   // Register access: event fields are don't-care, so they get noise
   function automatic req_item_type bus_access(input logic [OP_W-1:0] op,
                                               input logic [WORD_W-1:0] bus);
      req_item_type w;
      w.operation     = op;
      w.bus_word      = bus;
      w.event_channel = CH_W'($urandom);
      w.event_byte    = BYTE_W'($urandom);
      w.carrier_level = 1'($urandom);
      return w;
   endfunction

   // Line event: bus word is don't-care
   function automatic req_item_type event_word(input logic [OP_W-1:0] op,
                                               input logic [CH_W-1:0] ch,
                                               input logic [BYTE_W-1:0] b,
                                               input logic level);
      req_item_type w;
      w.operation     = op;
      w.bus_word      = WORD_W'($urandom);
      w.event_channel = ch;
      w.event_byte    = b;
      w.carrier_level = level;
      return w;
   endfunction

   // Mostly back-to-back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   task automatic note_failure(input string what, input mux_result_type want,
                               input mux_result_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t mismatch (%s): expected data=%h tx=%b ch=%0d byte=%h",
                  $realtime, what, want.read_data, want.tx_valid, want.tx_channel,
                  want.tx_byte);
         $display("   got data=%h tx=%b ch=%0d byte=%h",
                  got.read_data, got.tx_valid, got.tx_channel, got.tx_byte);
      end
   endtask

   // ----------------------------------------------------------- driving side
   // Called at a rising edge; returns once the word was taken and any gap after it passed.
   // With no gap, valid stays high and the next call swaps the payload.
   task automatic send_word(input req_item_type w);
      int gap;
      req_valid         <= 1'b1;
      req_operation     <= w.operation;
      req_bus_word      <= w.bus_word;
      req_event_channel <= w.event_channel;
      req_event_byte    <= w.event_byte;
      req_carrier_level <= w.carrier_level;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      gap = sender_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic command_then_read(input logic [CH_W-1:0] ch, input logic [CMD_W-1:0] cmd);
      send_word(bus_access(OP_CMD_WRITE, cmd_word(ch, cmd)));
      send_word(bus_access(OP_HOLD_READ, WORD_W'($urandom)));
   endtask

   // Drop valid and let every owed word come back, plus the pipeline tail
   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the threshold while idle, then read it back
   task automatic set_threshold(input int value);
      mux_result_type want;
      mux_result_type got;
      wait_for_quiet();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= THRESHOLD_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      ready_threshold = THR_W'(value);
      thresholds_used++;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== CSR_DATA_W'(value)) begin
         want = '0;
         got  = '0;
         want.read_data = WORD_W'(value);
         got.read_data  = csr_prdata[WORD_W-1:0];
         note_failure("threshold readback", want, got);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // ----------------------------------------------------------- tests
   // Field extremes, every command and operation, carrier loss, LF translation
   task automatic test_directed();
      req_item_type w;
      send_word(bus_access(OP_HOLD_READ, '1));               // holding word after reset
      command_then_read(3'd0, CMD_TX_STATUS);                // empty ring, reset threshold
      command_then_read(3'd3, CMD_POP);                      // empty queue, no loss yet
      send_word(event_word(OP_CARRIER, 3'd3, '0, 1'b1));
      command_then_read(3'd3, CMD_POP);                      // remembers carrier up
      send_word(event_word(OP_CARRIER, 3'd3, '1, 1'b0));
      command_then_read(3'd3, CMD_POP);                      // carrier lost bits
      command_then_read(3'd3, CMD_MODEM);
      send_word(event_word(OP_RX_BYTE, 3'd5, CHAR_LF, 1'b1));
      send_word(event_word(OP_RX_BYTE, 3'd5, '1, 1'b0));
      command_then_read(3'd5, CMD_POP);                      // newline comes back as CR
      command_then_read(3'd5, CMD_POP);
      command_then_read(3'd5, CMD_IN_STATUS);
      send_word(bus_access(OP_DATA_WRITE, '1));              // ch 7, byte ff, top bits set
      send_word(bus_access(OP_DATA_WRITE, 16'hF800));        // ch 0, byte 00, top bits set
      command_then_read(3'd7, CMD_TX_STATUS);
      command_then_read(3'd7, CMD_TAKE_BACK);                // ring goes empty again
      send_word(event_word(OP_TX_TICK, 3'd7, '1, 1'b1));     // tick on an empty ring
      send_word(event_word(OP_TX_TICK, 3'd0, '0, 1'b0));
      command_then_read(3'd0, CMD_UNUSED);                   // holding word kept
      w = event_word(OP_SPARE_6, '1, '1, 1'b1);
      w.bus_word = '1;
      send_word(w);
      w.operation = OP_SPARE_7;
      send_word(w);
   endtask

   // Overfill one transmit ring and one receive queue, then drain both
   task automatic test_ring_limits();
      logic [CH_W-1:0] ch;
      ch = CH_W'($urandom);
      for (int i = 0; i < TX_DEPTH; i++)
         send_word(bus_access(OP_DATA_WRITE, data_word(ch, BYTE_W'($urandom))));
      command_then_read(ch, CMD_TX_STATUS);
      command_then_read(ch, CMD_TAKE_BACK);
      send_word(bus_access(OP_DATA_WRITE, data_word(ch, BYTE_W'($urandom))));
      command_then_read(ch, CMD_TX_STATUS);
      for (int i = 0; i < TX_DEPTH; i++)
         send_word(event_word(OP_TX_TICK, ch, BYTE_W'($urandom), 1'($urandom)));
      command_then_read(ch, CMD_TAKE_BACK);
      for (int i = 0; i <= RX_DEPTH; i++)
         send_word(event_word(OP_RX_BYTE, ch, BYTE_W'($urandom), 1'($urandom)));
      for (int i = 0; i <= RX_DEPTH; i++)
         command_then_read(ch, CMD_POP);
   endtask

   // Mixed traffic aimed at two hot channels so rings and queues fill and empty.
   // fill_heavy favors writes and received bytes, otherwise ticks and pops.
   task automatic test_random_traffic(input int count, input bit fill_heavy);
      int                n;
      int                r;
      int                pick;
      int                next_mix;
      int                hot_base;
      int                cut[6];
      logic [CH_W-1:0]   ch;
      logic [CMD_W-1:0]  cmd;
      logic [BYTE_W-1:0] b;
      n        = 0;
      next_mix = 0;
      hot_base = $urandom_range(0, CHANNELS - 2);
      if (fill_heavy) cut = '{35, 60, 70, 92, 95, 99};
      else            cut = '{10, 18, 53, 91, 95, 99};
      while (n < count) begin
         if (n >= next_mix) begin
            sender_steady   = ($urandom_range(0, 3) == 0);
            receiver_steady = ($urandom_range(0, 3) == 0);
            next_mix += 40;
         end
         ch = ($urandom_range(0, 9) < 7) ? CH_W'(hot_base + $urandom_range(0, 1))
                                         : CH_W'($urandom);
         r  = $urandom_range(0, 99);
         if (r < cut[0]) begin
            send_word(bus_access(OP_DATA_WRITE, data_word(ch, BYTE_W'($urandom))));
         end else if (r < cut[1]) begin
            b = ($urandom_range(0, 9) == 0) ? CHAR_LF : BYTE_W'($urandom);
            send_word(event_word(OP_RX_BYTE, ch, b, 1'($urandom)));
         end else if (r < cut[2]) begin
            send_word(event_word(OP_TX_TICK, ch, BYTE_W'($urandom), 1'($urandom)));
         end else if (r < cut[3]) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)      cmd = CMD_POP;
            else if (pick < 50) cmd = CMD_TX_STATUS;
            else if (pick < 65) cmd = CMD_TAKE_BACK;
            else if (pick < 75) cmd = CMD_MODEM;
            else if (pick < 85) cmd = CMD_IN_STATUS;
            else begin
               do cmd = CMD_W'($urandom);
               while (cmd == CMD_POP || cmd == CMD_MODEM || cmd == CMD_IN_STATUS ||
                      cmd == CMD_TX_STATUS || cmd == CMD_TAKE_BACK);
            end
            send_word(bus_access(OP_CMD_WRITE, cmd_word(ch, cmd)));
            // a command is normally followed by the read that fetches its answer
            if ($urandom_range(0, 3) != 0) begin
               send_word(bus_access(OP_HOLD_READ, WORD_W'($urandom)));
               n++;
            end
         end else if (r < cut[4]) begin
            send_word(bus_access(OP_HOLD_READ, WORD_W'($urandom)));
         end else if (r < cut[5]) begin
            send_word(event_word(OP_CARRIER, ch, BYTE_W'($urandom), 1'($urandom)));
         end else begin
            send_word(event_word($urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7,
                                 ch, BYTE_W'($urandom), 1'($urandom)));
         end
         n++;
      end
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
   endtask

   // ----------------------------------------------------------- response side
   // Random back-pressure on the response channel
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!receiver_steady && $urandom_range(0, 2) == 0) stall_left <= pick_gap();
      end
   end

   // Prediction on every accepted request word, checking on every accepted
   // response word. Both sample the values held before this edge.
   always @(posedge clock) begin
      req_item_type   seen;
      mux_result_type got;
      mux_result_type want;
      bit             moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_valid && req_ready) begin
            seen.operation     = req_operation;
            seen.bus_word      = req_bus_word;
            seen.event_channel = req_event_channel;
            seen.event_byte    = req_event_byte;
            seen.carrier_level = req_carrier_level;
            due_words.push_back(apply_bus_word(seen));
            moved = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            got.read_data  = rsp_read_data;
            got.tx_valid   = rsp_tx_valid;
            got.tx_channel = rsp_tx_channel;
            got.tx_byte    = rsp_tx_byte;
            words_checked++;
            if (due_words.size() == 0) begin
               note_failure("unexpected word", '0, got);
            end else begin
               want = due_words.pop_front();
               if (got.read_data !== want.read_data || got.tx_valid !== want.tx_valid ||
                   got.tx_channel !== want.tx_channel || got.tx_byte !== want.tx_byte)
                  note_failure("response", want, got);
            end
            moved = 1'b1;
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
      end
   end

   // Watchdog: nothing moving for too long means a hang
   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("watchdog: no word moved for %0d cycles, %0d words still owed",
               IDLE_LIMIT, due_words.size());
      $display("testbench: FAIL");
      $finish;
   end

   // ----------------------------------------------------------- sequence
   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_operation     = '0;
      req_bus_word      = '0;
      req_event_channel = '0;
      req_event_byte    = '0;
      req_carrier_level = 1'b0;
      rsp_ready         = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      mismatches        = 0;
      words_checked     = 0;
      bytes_drained     = 0;
      bytes_popped      = 0;
      ring_drops        = 0;
      queue_drops       = 0;
      thresholds_used   = 1;       // reset value counts as the first setting
      idle_cycles       = 0;
      stall_left        = 0;
      sender_steady     = 1'b0;
      receiver_steady   = 1'b0;
      clear_mux_copy();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_directed();                        // runs at the reset threshold
      set_threshold(TX_DEPTH);
      test_ring_limits();
      set_threshold(0);
      test_random_traffic(PHASE_WORDS, 1'b1);
      set_threshold(TX_DEPTH);
      test_random_traffic(PHASE_WORDS, 1'b0);
      set_threshold(1);
      test_random_traffic(PHASE_WORDS, 1'b1);
      set_threshold($urandom_range(0, TX_DEPTH));
      test_random_traffic(PHASE_WORDS, 1'b0);
      set_threshold(TX_DEPTH - 1);
      test_random_traffic(PHASE_WORDS, 1'b1);

      wait_for_quiet();
      if (due_words.size() != 0) begin
         mismatches += due_words.size();
         $display("%0d expected words never arrived", due_words.size());
      end

      $display("checked %0d response words across %0d threshold settings",
               words_checked, thresholds_used);
      $display("%0d bytes drained, %0d popped, full-ring drops %0d, full-queue drops %0d",
               bytes_drained, bytes_popped, ring_drops, queue_drops);
      $display("mismatches %0d", mismatches);
      if (mismatches == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
